// ===== design/tsp_pkg.sv =====
// Shared types and constants for the exhaustive tour search block.
// No dependencies; every other file in the design imports it.
package tsp_pkg;

    localparam int MAX_CITIES_DEF = 16;
    // width of the visited mask, bounds the cities a search can use
    localparam int CITY_CAP       = 16;

    localparam int COST_W     = 16;
    localparam int PSUM_W     = 21;
    localparam int CAND_W     = 6;
    localparam int RESULT_W   = 30;
    localparam int NCITY_W    = 5;
    localparam int PIDX_W     = 4;
    localparam int PCNT_W     = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_ADDR_W = 2;

    localparam logic [RESULT_W-1:0] NO_TOUR_COST = 30'd1000000000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NUM_CITIES = 2'd0,
        CFG_PART_INDEX = 2'd1,
        CFG_PART_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRY,
        ST_EVAL,
        ST_CLOSE,
        ST_POP,
        ST_DONE
    } search_state_t;

    typedef struct packed {
        logic               start;
        logic [NCITY_W-1:0] num_cities;
        logic [PIDX_W-1:0]  part_index;
        logic [PCNT_W-1:0]  part_count;
    } search_cmd_t;

    typedef struct packed {
        logic                busy;
        logic                valid;
        logic [RESULT_W-1:0] min_cost;
        logic                no_tour;
    } search_res_t;

endpackage

// ===== design/tsp_exhaustive_search_top.sv =====
// Top level of the exhaustive tour search: config registers, stream ports, result register.
// Depends on tsp_pkg, tsp_cost_store and tsp_search.
//
//  channel  | direction | fields (tdata / tuser)
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | tdata: row, col, cost_value ; tuser: mode
//  m_       | out       | tdata: min_cost ; tuser: no_tour
//  cfg_     | in        | num_cities, partition_index, partition_count
//
// A cost word is stored when accepted. A start word runs the depth-first search:
// each edge tried is a cost read, then a compare; visited cities are skipped; a backtrack pops a frame,
// after a closing-edge check at a leaf; over up to (n-1)! tours for n cities, less with pruning;
// the single cost store read port sets this pace. With no first hop the search goes straight to
// its done state and offers the result to the output register.
// Reset is synchronous, active low; the cost store is not cleared.
// s_tready drops while a search runs or its result waits for a free output register.
module tsp_exhaustive_search_top #(
    parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // row[3:0], col[7:4], cost_value[23:8]
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // min_cost[29:0], zero pad
    output logic                              m_tuser,   // no_tour
    input  logic                              cfg_wr_en,
    input  logic [tsp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tsp_pkg::CFG_W-1:0]         cfg_wdata
);
    import tsp_pkg::*;

    localparam int CW = $clog2(MAX_CITIES);

    logic [NCITY_W-1:0]  num_cities_reg;
    logic [PIDX_W-1:0]   part_index_reg;
    logic [PCNT_W-1:0]   part_count_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [RESULT_W-1:0] min_cost_reg;
    logic                no_tour_reg;

    search_cmd_t         cmd;
    search_res_t         res;
    logic                res_ack;
    logic                s_accept;
    logic                cost_wr_en;
    logic                cost_rd_en;
    logic [CW-1:0]       cost_rd_row;
    logic [CW-1:0]       cost_rd_col;
    logic [COST_W-1:0]   cost_rd_data;

    assign s_tready   = !res.busy;
    assign s_accept   = s_tvalid && s_tready;
    assign cost_wr_en = s_accept && (s_tuser == MODE_WRITE);

    assign cmd.start      = s_accept && (s_tuser == MODE_START);
    assign cmd.num_cities = num_cities_reg;
    assign cmd.part_index = part_index_reg;
    assign cmd.part_count = part_count_reg;

    // result leaves the search as soon as the output register is free
    assign res_ack       = res.valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = res_ack || (m_tvalid_reg && !m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(32 - RESULT_W){1'b0}}, min_cost_reg};
    assign m_tuser  = no_tour_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cities_reg <= NCITY_W'(4);
            part_index_reg <= '0;
            part_count_reg <= PCNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_NUM_CITIES: num_cities_reg <= cfg_wdata[NCITY_W-1:0];
                CFG_PART_INDEX: part_index_reg <= cfg_wdata[PIDX_W-1:0];
                CFG_PART_COUNT: part_count_reg <= cfg_wdata[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            min_cost_reg <= res.min_cost;
            no_tour_reg  <= res.no_tour;
        end
    end

    tsp_cost_store #(
        .MAX_CITIES (MAX_CITIES)
    ) u_cost_store (
        .aclk    (aclk),
        .wr_en   (cost_wr_en),
        .wr_row  (s_tdata[3:0]),
        .wr_col  (s_tdata[7:4]),
        .wr_data (s_tdata[23:8]),
        .rd_en   (cost_rd_en),
        .rd_row  (cost_rd_row),
        .rd_col  (cost_rd_col),
        .rd_data (cost_rd_data)
    );

    tsp_search #(
        .MAX_CITIES (MAX_CITIES)
    ) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .res_ack      (res_ack),
        .res          (res),
        .cost_rd_en   (cost_rd_en),
        .cost_rd_row  (cost_rd_row),
        .cost_rd_col  (cost_rd_col),
        .cost_rd_data (cost_rd_data)
    );

endmodule

// ===== design/tsp_cost_store.sv =====
// Cost matrix store: one write port from the input stream, one registered read port.
// Depends on tsp_pkg.
module tsp_cost_store #(
    parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [3:0]                      wr_row,
    input  logic [3:0]                      wr_col,
    input  logic [tsp_pkg::COST_W-1:0]      wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_CITIES)-1:0]   rd_row,
    input  logic [$clog2(MAX_CITIES)-1:0]   rd_col,
    output logic [tsp_pkg::COST_W-1:0]      rd_data
);
    import tsp_pkg::*;

    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);

    logic [COST_W-1:0] mem [DEPTH];
    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    // entries outside the matrix are dropped
    assign wr_ok   = wr_en && (int'(wr_row) < MAX_CITIES) && (int'(wr_col) < MAX_CITIES);
    assign wr_addr = AW'(int'(wr_row) * MAX_CITIES + int'(wr_col));
    assign rd_addr = AW'(int'(rd_row) * MAX_CITIES + int'(rd_col));

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/tsp_search.sv =====
// Depth-first tour search sequencer with a frame stack memory and branch pruning.
// Depends on tsp_pkg; reads costs through the tsp_cost_store port.
module tsp_search #(
    parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tsp_pkg::search_cmd_t            cmd,
    input  logic                            res_ack,
    output tsp_pkg::search_res_t            res,
    output logic                            cost_rd_en,
    output logic [$clog2(MAX_CITIES)-1:0]   cost_rd_row,
    output logic [$clog2(MAX_CITIES)-1:0]   cost_rd_col,
    input  logic [tsp_pkg::COST_W-1:0]      cost_rd_data
);
    import tsp_pkg::*;

    localparam int CW  = $clog2(MAX_CITIES);
    localparam int CAP = (MAX_CITIES < CITY_CAP) ? MAX_CITIES : CITY_CAP;
    localparam int SW  = $clog2(CAP);
    localparam int FW  = SW + PSUM_W + CAND_W;

    search_state_t       state_reg, state_next;
    logic [SW-1:0]       depth_reg, depth_next;
    logic [SW-1:0]       cur_reg, cur_next;
    logic [PSUM_W-1:0]   psum_reg, psum_next;
    logic [CAND_W-1:0]   cand_reg, cand_next;
    logic [CAP-1:0]      visited_reg, visited_next;
    logic [RESULT_W-1:0] best_reg, best_next;
    logic                none_reg, none_next;
    logic [NCITY_W-1:0]  n_reg, n_next;
    logic [PCNT_W-1:0]   pc_reg, pc_next;

    // frame stack: parent city, its partial sum, next candidate to try
    logic [FW-1:0]       stack_mem [CAP];
    logic [FW-1:0]       stack_rd_data;
    logic [FW-1:0]       stack_wr_data;
    logic                stack_wr_en;
    logic                stack_rd_en;

    logic [CAND_W-1:0]   step;
    logic [CAND_W-1:0]   cand_adv;
    logic                at_leaf;
    logic                cand_out;
    logic [PSUM_W-1:0]   new_sum;
    logic [NCITY_W-1:0]  n_eff;
    logic                start_none;

    assign step     = (depth_reg == '0) ? CAND_W'(pc_reg) : CAND_W'(1);
    assign cand_adv = cand_reg + step;
    assign at_leaf  = (NCITY_W'(depth_reg) + NCITY_W'(1)) == n_reg;
    assign cand_out = cand_reg >= CAND_W'(n_reg);
    assign new_sum  = psum_reg + PSUM_W'(cost_rd_data);

    assign stack_wr_data = {cur_reg, psum_reg, cand_adv};

    assign n_eff = (cmd.num_cities > NCITY_W'(CAP)) ? NCITY_W'(CAP) : cmd.num_cities;
    // a first hop exists only if the share index lands on a city in use
    assign start_none = (n_eff < NCITY_W'(2)) || (cmd.part_count == '0)
                     || (PCNT_W'(cmd.part_index) >= cmd.part_count)
                     || ((NCITY_W'(cmd.part_index) + NCITY_W'(1)) >= n_eff);

    // pushes happen only in EVAL and pops read only from TRY/CLOSE, so the
    // stack never sees a read and write of one frame in the same cycle
    always_ff @(posedge aclk) begin
        if (stack_wr_en) begin
            stack_mem[depth_reg] <= stack_wr_data;
        end
        if (stack_rd_en) begin
            stack_rd_data <= stack_mem[depth_reg - SW'(1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            cur_reg     <= '0;
            psum_reg    <= '0;
            cand_reg    <= '0;
            visited_reg <= CAP'(1);
            best_reg    <= NO_TOUR_COST;
            none_reg    <= 1'b1;
            n_reg       <= '0;
            pc_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            cur_reg     <= cur_next;
            psum_reg    <= psum_next;
            cand_reg    <= cand_next;
            visited_reg <= visited_next;
            best_reg    <= best_next;
            none_reg    <= none_next;
            n_reg       <= n_next;
            pc_reg      <= pc_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        cur_next     = cur_reg;
        psum_next    = psum_reg;
        cand_next    = cand_reg;
        visited_next = visited_reg;
        best_next    = best_reg;
        none_next    = none_reg;
        n_next       = n_reg;
        pc_next      = pc_reg;
        stack_wr_en  = 1'b0;
        stack_rd_en  = 1'b0;
        cost_rd_en   = 1'b0;
        cost_rd_row  = CW'(cur_reg);
        cost_rd_col  = CW'(cand_reg[SW-1:0]);
        res.busy     = (state_reg != ST_IDLE);
        res.valid    = 1'b0;
        res.min_cost = best_reg;
        res.no_tour  = none_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    n_next       = n_eff;
                    pc_next      = cmd.part_count;
                    cand_next    = CAND_W'(cmd.part_index) + CAND_W'(1);
                    depth_next   = '0;
                    cur_next     = '0;
                    psum_next    = '0;
                    visited_next = CAP'(1);
                    best_next    = NO_TOUR_COST;
                    none_next    = start_none;
                    state_next   = start_none ? ST_DONE : ST_TRY;
                end
            end
            ST_TRY: begin
                if (at_leaf) begin
                    // all cities placed: fetch the edge back to city zero
                    cost_rd_en  = 1'b1;
                    cost_rd_col = '0;
                    state_next  = ST_CLOSE;
                end else if (cand_out) begin
                    if (depth_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        stack_rd_en = 1'b1;
                        state_next  = ST_POP;
                    end
                end else if (visited_reg[cand_reg[SW-1:0]]) begin
                    cand_next = cand_adv;
                end else begin
                    cost_rd_en = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // prune: costs are nonnegative, so a sum not below best can't win
                if (RESULT_W'(new_sum) < best_reg) begin
                    stack_wr_en                       = 1'b1;
                    visited_next[cand_reg[SW-1:0]]    = 1'b1;
                    cur_next                          = cand_reg[SW-1:0];
                    psum_next                         = new_sum;
                    depth_next                        = depth_reg + SW'(1);
                    cand_next                         = CAND_W'(1);
                end else begin
                    cand_next = cand_adv;
                end
                state_next = ST_TRY;
            end
            ST_CLOSE: begin
                if (RESULT_W'(new_sum) < best_reg) begin
                    best_next = RESULT_W'(new_sum);
                end
                stack_rd_en = 1'b1;
                state_next  = ST_POP;
            end
            ST_POP: begin
                visited_next[cur_reg] = 1'b0;
                cur_next   = stack_rd_data[FW-1 -: SW];
                psum_next  = stack_rd_data[PSUM_W+CAND_W-1 -: PSUM_W];
                cand_next  = stack_rd_data[CAND_W-1:0];
                depth_next = depth_reg - SW'(1);
                state_next = ST_TRY;
            end
            ST_DONE: begin
                res.valid = 1'b1;
                if (res_ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
